FILE: hw/rtl/srlp_pkg.sv
package srlp_pkg;

    localparam logic [7:0]  NEWLINE_BYTE    = 8'h0A;
    localparam logic [7:0]  DIGIT_ZERO      = 8'h30;
    localparam logic [7:0]  DIGIT_NINE      = 8'h39;
    localparam logic [4:0]  COL_MAX         = 5'd31;
    localparam logic [4:0]  MIN_LINE_COLS   = 5'd24;
    localparam logic [4:0]  RH_COL_FIRST    = 5'd3;
    localparam logic [4:0]  RH_COL_LAST     = 5'd7;
    localparam logic [4:0]  TEMP_COL_FIRST  = 5'd11;
    localparam logic [4:0]  TEMP_COL_LAST   = 5'd15;
    localparam logic [4:0]  CO2_COL_FIRST   = 5'd19;
    localparam logic [4:0]  CO2_COL_LAST    = 5'd23;

    localparam int          ACC_W           = 17;
    localparam int          PROD_W          = 34;
    localparam int          RECIP_SHIFT     = 20;
    localparam logic signed [ACC_W:0] TEMP_OFFSET = 18'sd1000;
    // ceil(2^20 / 10), exact for dividends below 2^18
    localparam logic [ACC_W-1:0] RECIP10    = 17'd104858;

    typedef enum logic [1:0] {
        OP_RH,
        OP_TEMP,
        OP_CO2,
        OP_EOL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       err;
    } cmd_t;

endpackage

FILE: hw/rtl/srlp_front.sv
module srlp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    output logic            push,
    output srlp_pkg::cmd_t  push_cmd,
    input  logic            q_ready
);
    import srlp_pkg::*;

    logic [4:0] col_reg, col_next;
    logic       bad_reg, bad_next;
    logic       accept;
    logic       is_digit;
    logic       in_rh, in_temp, in_co2;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    always_comb begin
        is_digit = (s_rx_byte >= DIGIT_ZERO) && (s_rx_byte <= DIGIT_NINE);
        in_rh    = (col_reg >= RH_COL_FIRST) && (col_reg <= RH_COL_LAST);
        in_temp  = (col_reg >= TEMP_COL_FIRST) && (col_reg <= TEMP_COL_LAST);
        in_co2   = (col_reg >= CO2_COL_FIRST) && (col_reg <= CO2_COL_LAST);

        push           = 1'b0;
        push_cmd.op    = OP_EOL;
        push_cmd.digit = 4'(s_rx_byte - DIGIT_ZERO);
        push_cmd.err   = (col_reg < MIN_LINE_COLS) || bad_reg;
        col_next       = col_reg;
        bad_next       = bad_reg;

        if (accept) begin
            if (s_rx_byte == NEWLINE_BYTE) begin
                push     = 1'b1;
                col_next = '0;
                bad_next = 1'b0;
            end else begin
                if (in_rh || in_temp || in_co2) begin
                    if (!is_digit) begin
                        bad_next = 1'b1;
                    end else begin
                        push = 1'b1;
                        priority if (in_rh) begin
                            push_cmd.op = OP_RH;
                        end else if (in_temp) begin
                            push_cmd.op = OP_TEMP;
                        end else begin
                            push_cmd.op = OP_CO2;
                        end
                    end
                end
                if (col_reg < COL_MAX) begin
                    col_next = col_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            bad_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            bad_reg <= bad_next;
        end
    end

endmodule

FILE: hw/rtl/srlp_queue.sv
module srlp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  srlp_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    input  logic            pop,
    output srlp_pkg::cmd_t  pop_cmd,
    output logic            pop_valid
);
    import srlp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/srlp_back.sv
module srlp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  srlp_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [16:0]         m_co2_ppm,
    output logic signed [14:0]  m_temp_value,
    output logic [13:0]         m_rh_value,
    output logic                m_format_error
);
    import srlp_pkg::*;

    logic [ACC_W-1:0]  rh_acc_reg, rh_acc_next;
    logic [ACC_W-1:0]  temp_acc_reg, temp_acc_next;
    logic [ACC_W-1:0]  co2_acc_reg, co2_acc_next;

    // divide stage
    logic              mul_valid_reg, mul_valid_next;
    logic              mul_err_reg;
    logic              mul_neg_reg;
    logic [ACC_W-1:0]  mul_co2_reg;
    logic [PROD_W-1:0] mul_rh_prod_reg;
    logic [PROD_W-1:0] mul_temp_prod_reg;

    // output stage
    logic              out_valid_reg, out_valid_next;
    logic [16:0]       out_co2_reg;
    logic signed [14:0] out_temp_reg;
    logic [13:0]       out_rh_reg;
    logic              out_err_reg;

    logic              out_load, mul_load, eol_pop;
    logic signed [ACC_W:0] temp_diff;
    logic              temp_neg;
    logic [ACC_W-1:0]  temp_mag;
    logic [13:0]       rh_quot, temp_quot;
    logic [ACC_W-1:0]  digit_ext;

    assign out_load = !out_valid_reg || m_ready;
    assign mul_load = !mul_valid_reg || out_load;
    assign q_pop    = q_valid && mul_load;
    assign eol_pop  = q_pop && (q_cmd.op == OP_EOL);

    assign digit_ext = ACC_W'(q_cmd.digit);

    always_comb begin
        rh_acc_next   = rh_acc_reg;
        temp_acc_next = temp_acc_reg;
        co2_acc_next  = co2_acc_reg;
        if (q_pop) begin
            unique case (q_cmd.op)
                OP_RH: begin
                    rh_acc_next = {rh_acc_reg[ACC_W-4:0], 3'b000}
                                + {rh_acc_reg[ACC_W-2:0], 1'b0} + digit_ext;
                end
                OP_TEMP: begin
                    temp_acc_next = {temp_acc_reg[ACC_W-4:0], 3'b000}
                                  + {temp_acc_reg[ACC_W-2:0], 1'b0} + digit_ext;
                end
                OP_CO2: begin
                    co2_acc_next = {co2_acc_reg[ACC_W-4:0], 3'b000}
                                 + {co2_acc_reg[ACC_W-2:0], 1'b0} + digit_ext;
                end
                OP_EOL: begin
                    rh_acc_next   = '0;
                    temp_acc_next = '0;
                    co2_acc_next  = '0;
                end
                default: begin
                    rh_acc_next = rh_acc_reg;
                end
            endcase
        end
    end

    // temperature is offset first, then divided by magnitude to truncate toward zero
    always_comb begin
        temp_diff = $signed({1'b0, temp_acc_reg}) - TEMP_OFFSET;
        temp_neg  = temp_diff[ACC_W];
        temp_mag  = temp_neg ? ACC_W'(-temp_diff) : temp_diff[ACC_W-1:0];
    end

    always_comb begin
        mul_valid_next = mul_valid_reg;
        if (mul_load) begin
            mul_valid_next = eol_pop;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = mul_valid_reg;
        end
    end

    assign rh_quot   = mul_rh_prod_reg[RECIP_SHIFT +: 14];
    assign temp_quot = mul_temp_prod_reg[RECIP_SHIFT +: 14];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rh_acc_reg    <= '0;
            temp_acc_reg  <= '0;
            co2_acc_reg   <= '0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rh_acc_reg    <= rh_acc_next;
            temp_acc_reg  <= temp_acc_next;
            co2_acc_reg   <= co2_acc_next;
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (eol_pop) begin
            mul_err_reg       <= q_cmd.err;
            mul_neg_reg       <= temp_neg;
            mul_co2_reg       <= co2_acc_reg;
            mul_rh_prod_reg   <= PROD_W'(rh_acc_reg) * PROD_W'(RECIP10);
            mul_temp_prod_reg <= PROD_W'(temp_mag) * PROD_W'(RECIP10);
        end
        if (out_load && mul_valid_reg) begin
            out_err_reg <= mul_err_reg;
            if (mul_err_reg) begin
                out_co2_reg  <= '0;
                out_temp_reg <= '0;
                out_rh_reg   <= '0;
            end else begin
                out_co2_reg  <= mul_co2_reg;
                out_rh_reg   <= rh_quot;
                out_temp_reg <= mul_neg_reg ? -$signed({1'b0, temp_quot})
                                            : $signed({1'b0, temp_quot});
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_co2_ppm      = out_co2_reg;
    assign m_temp_value   = out_temp_reg;
    assign m_rh_value     = out_rh_reg;
    assign m_format_error = out_err_reg;

endmodule

FILE: hw/rtl/sensor_reply_line_parser_top.sv
// sensor reply line parser
// input channel: one ascii byte of the sensor reply per request on s_rx_byte,
// s_valid / s_ready handshake. digits at columns 3-7, 11-15 and 19-23 feed
// the humidity, temperature and co2 accumulators; a newline closes the line.
// result channel: one request per newline on m_co2_ppm, m_temp_value
// ((raw - 1000) / 10, toward zero), m_rh_value (raw / 10) and m_format_error
// (short line or non-digit in a digit column; values then read zero).
// throughput: one byte per cycle while the queue has room. the front end
// tracks the column and pushes digit and end-of-line commands into a
// QUEUE_DEPTH entry queue; the back end pops one command per cycle while its
// multiply stage can load, accumulating digits, and runs an end-of-line
// through a reciprocal multiply stage and the output register. a newline's
// command passes the queue, that stage and the output register to m_valid.
// a stalled receiver holds the output register; the back end keeps popping
// until its two stages fill, then the queue fills and s_ready drops.
// reset (aresetn low, synchronous) empties the queue and both stages and
// clears column count, error flag and accumulators.
module sensor_reply_line_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [16:0]         m_co2_ppm,
    output logic signed [14:0]  m_temp_value,
    output logic [13:0]         m_rh_value,
    output logic                m_format_error
);
    import srlp_pkg::*;

    logic push, q_ready, q_valid, q_pop;
    cmd_t push_cmd, q_cmd;

    srlp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready)
    );

    srlp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_ready(q_ready),
        .pop       (q_pop),
        .pop_cmd   (q_cmd),
        .pop_valid (q_valid)
    );

    srlp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_co2_ppm     (m_co2_ppm),
        .m_temp_value  (m_temp_value),
        .m_rh_value    (m_rh_value),
        .m_format_error(m_format_error)
    );

endmodule

FILE: hw/rtl/srlp_checker.sv
module srlp_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [16:0]         m_co2_ppm,
    input  logic signed [14:0]  m_temp_value,
    input  logic [13:0]         m_rh_value,
    input  logic                m_format_error
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_co2_ppm) && $stable(m_temp_value)
            && $stable(m_rh_value) && $stable(m_format_error))
        else $error("result changed while stalled");

    // a bad line reports zero values
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_format_error |-> m_co2_ppm == 17'd0 && m_temp_value == 15'sd0
            && m_rh_value == 14'd0)
        else $error("format error with nonzero values");

    // good line values stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_format_error |-> m_temp_value >= -15'sd100
            && m_temp_value <= 15'sd9899 && m_rh_value <= 14'd9999
            && m_co2_ppm <= 17'd99999)
        else $error("result value out of range");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind sensor_reply_line_parser_top srlp_checker u_srlp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_co2_ppm     (m_co2_ppm),
    .m_temp_value  (m_temp_value),
    .m_rh_value    (m_rh_value),
    .m_format_error(m_format_error)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import srlp_pkg::*;

    localparam int TEMP_BIAS   = 1000;
    localparam int DEC_BASE    = 10;
    localparam int ITEM_TARGET = 650;
    localparam int LINE_TARGET = 20;
    localparam int LONG_HOLD   = 150;
    localparam int DRAIN_WAIT  = 20;
    localparam int REPORT_MAX  = 10;
    localparam int CYCLE_LIMIT = 250000;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_NINE} fill_t;
    typedef enum int {LINE_GOOD, LINE_BAD_DIGIT, LINE_SHORT, LINE_NOISE} line_kind_t;

    typedef struct {
        logic [16:0]        co2;
        logic signed [14:0] temp;
        logic [13:0]        rh;
        logic               err;
    } reading_t;

    class line_scoreboard;
        reading_t    readings_due[$];
        logic [4:0]  col;
        logic [16:0] co2_acc;
        logic [16:0] temp_acc;
        logic [16:0] rh_acc;
        logic        bad;
        int          mismatches;

        function new();
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            col      = '0;
            co2_acc  = '0;
            temp_acc = '0;
            rh_acc   = '0;
            bad      = 1'b0;
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        function void note_byte(logic [7:0] b);
            reading_t    r;
            int          t;
            logic [16:0] q;
            logic        is_digit;
            logic [3:0]  d;
            if (b == NEWLINE_BYTE) begin
                r.err  = (col < MIN_LINE_COLS) || bad;
                r.co2  = '0;
                r.temp = '0;
                r.rh   = '0;
                if (!r.err) begin
                    r.co2  = co2_acc;
                    // int division truncates toward zero
                    t      = (int'(temp_acc) - TEMP_BIAS) / DEC_BASE;
                    r.temp = t[14:0];
                    q      = 17'(rh_acc / DEC_BASE);
                    r.rh   = q[13:0];
                end
                readings_due.push_back(r);
                clear_line();
                return;
            end
            is_digit = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
            d = is_digit ? 4'(b - DIGIT_ZERO) : 4'd0;
            if (col >= RH_COL_FIRST && col <= RH_COL_LAST) begin
                if (!is_digit) bad = 1'b1;
                else rh_acc = 17'(rh_acc * DEC_BASE + d);
            end else if (col >= TEMP_COL_FIRST && col <= TEMP_COL_LAST) begin
                if (!is_digit) bad = 1'b1;
                else temp_acc = 17'(temp_acc * DEC_BASE + d);
            end else if (col >= CO2_COL_FIRST && col <= CO2_COL_LAST) begin
                if (!is_digit) bad = 1'b1;
                else co2_acc = 17'(co2_acc * DEC_BASE + d);
            end
            if (col < COL_MAX) col = col + 5'd1;
        endfunction

        function void check_reading(logic [16:0] co2, logic signed [14:0] temp,
                                    logic [13:0] rh, logic err);
            reading_t r;
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with no line pending: co2=%0d temp=%0d rh=%0d err=%b",
                             $realtime, co2, temp, rh, err);
                return;
            end
            r = readings_due.pop_front();
            if (co2 !== r.co2 || temp !== r.temp || rh !== r.rh || err !== r.err) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"%0t: mismatch: exp co2=%0d temp=%0d rh=%0d err=%b, ",
                              "got co2=%0d temp=%0d rh=%0d err=%b"},
                             $realtime, r.co2, r.temp, r.rh, r.err, co2, temp, rh, err);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_rx_byte = 8'h00;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [16:0]         m_co2_ppm;
    logic signed [14:0]  m_temp_value;
    logic [13:0]         m_rh_value;
    logic                m_format_error;

    line_scoreboard sb = new();
    logic [7:0]     line_bytes[$];
    int             bytes_sent = 0;
    bit             hold_req = 1'b0;

    sensor_reply_line_parser_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_co2_ppm     (m_co2_ppm),
        .m_temp_value  (m_temp_value),
        .m_rh_value    (m_rh_value),
        .m_format_error(m_format_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic fill_t pick_fill();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return FILL_ZERO;
        if (r == 1) return FILL_NINE;
        return FILL_RANDOM;
    endfunction

    function automatic logic [7:0] digit_char(fill_t mode);
        if (mode == FILL_ZERO) return DIGIT_ZERO;
        if (mode == FILL_NINE) return DIGIT_NINE;
        return 8'(DIGIT_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_but_newline();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == NEWLINE_BYTE) b = 8'h0D;
        return b;
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do b = any_but_newline(); while (b >= DIGIT_ZERO && b <= DIGIT_NINE);
        return b;
    endfunction

    // reply layout: " H ddddd T ddddd Z ddddd", blanks or random printables where H, T, Z stand
    function automatic void fill_good(fill_t rh_mode, fill_t temp_mode, fill_t co2_mode);
        line_bytes.delete();
        for (int c = 0; c < MIN_LINE_COLS; c++) begin
            if (c >= RH_COL_FIRST && c <= RH_COL_LAST)
                line_bytes.push_back(digit_char(rh_mode));
            else if (c >= TEMP_COL_FIRST && c <= TEMP_COL_LAST)
                line_bytes.push_back(digit_char(temp_mode));
            else if (c >= CO2_COL_FIRST && c <= CO2_COL_LAST)
                line_bytes.push_back(digit_char(co2_mode));
            else if ($urandom_range(0, 4) == 0)
                line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            else
                line_bytes.push_back(8'h20);
        end
    endfunction

    function automatic void build_line(line_kind_t kind);
        int n;
        int pos;
        case (kind)
            LINE_GOOD, LINE_BAD_DIGIT: begin
                fill_good(pick_fill(), pick_fill(), pick_fill());
                if (kind == LINE_BAD_DIGIT) begin
                    pos = $urandom_range(0, 14);
                    pos = RH_COL_FIRST + (pos / 5) * 8 + (pos % 5);
                    line_bytes[pos] = non_digit();
                end
                // trailer long enough to push the column past saturation at times
                if ($urandom_range(0, 3) != 0) begin
                    n = $urandom_range(1, 14);
                    repeat (n) line_bytes.push_back(any_but_newline());
                end
            end
            LINE_SHORT: begin
                fill_good(pick_fill(), pick_fill(), pick_fill());
                n = $urandom_range(0, MIN_LINE_COLS - 1);
                while (line_bytes.size() > n) void'(line_bytes.pop_back());
            end
            default: begin
                line_bytes.delete();
                n = $urandom_range(1, 40);
                repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        line_bytes.push_back(NEWLINE_BYTE);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_line(input bit calm);
        foreach (line_bytes[i]) send_byte(line_bytes[i], calm);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        int calm_left;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                sb.check_reading(m_co2_ppm, m_temp_value, m_rh_value, m_format_error);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(50, 200);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (calm_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : byte_source
        int lines;
        int r;
        line_kind_t kind;
        lines = 0;
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);

        // full-scale humidity and co2, lowest temperature
        fill_good(FILL_NINE, FILL_ZERO, FILL_NINE);
        line_bytes.push_back(NEWLINE_BYTE);
        send_line(1'b0);
        // empty line
        line_bytes.delete();
        line_bytes.push_back(NEWLINE_BYTE);
        send_line(1'b0);
        // short line with the neighbors of the digit range in digit columns
        line_bytes = '{8'h00, 8'hFF, 8'h48, DIGIT_ZERO - 8'd1, DIGIT_NINE + 8'd1,
                       NEWLINE_BYTE};
        send_line(1'b0);

        while (bytes_sent < ITEM_TARGET || lines < LINE_TARGET) begin
            if (lines == 8) begin
                // receiver goes quiet while a burst of newlines piles up
                hold_req = 1'b1;
                repeat (14) begin
                    line_bytes.delete();
                    line_bytes.push_back(digit_char(FILL_RANDOM));
                    line_bytes.push_back(NEWLINE_BYTE);
                    send_line(1'b1);
                end
            end
            if (lines == 14) wait_all_results();
            r = $urandom_range(0, 99);
            if (r < 60)      kind = LINE_GOOD;
            else if (r < 75) kind = LINE_BAD_DIGIT;
            else if (r < 87) kind = LINE_SHORT;
            else             kind = LINE_NOISE;
            build_line(kind);
            send_line($urandom_range(0, 3) == 0);
            lines++;
        end

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/srlp_pkg.sv
hw/rtl/srlp_front.sv
hw/rtl/srlp_queue.sv
hw/rtl/srlp_back.sv
hw/rtl/sensor_reply_line_parser_top.sv
hw/rtl/srlp_checker.sv
sim/tb_top.sv
